[sv/c3zp_pkg.sv]
// Shared types and constants for the 3x3 zero-padded convolution block.
// No dependencies; used by c3zp_seq, c3zp_mac, the top level and the testbench.
`timescale 1ns / 1ps

package c3zp_pkg;

  localparam int PixW          = 16;
  localparam int CoeffW        = 16;
  localparam int ProdW         = PixW + CoeffW;
  localparam int GrpW          = ProdW + 2;
  localparam int SumW          = 36;
  localparam int GeomW         = 11;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 3 * CoeffW;
  localparam int Taps          = 9;
  localparam int CoeffFracBits = 14;

  localparam logic [CoeffW-1:0] BoxCoeff =
    CoeffW'((2 * (1 << CoeffFracBits) + 9) / 18);
  localparam logic [CfgDataW-1:0] CoeffRowReset = {BoxCoeff, BoxCoeff, BoxCoeff};

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgImageWidth  = 3'd0;
  localparam cfg_idx_t CfgImageHeight = 3'd1;
  localparam cfg_idx_t CfgCoeffTop    = 3'd2;
  localparam cfg_idx_t CfgCoeffMid    = 3'd3;
  localparam cfg_idx_t CfgCoeffBot    = 3'd4;

  // per-word control carried alongside the pixel data
  typedef struct packed {
    logic [Taps-1:0] mask;    // window tap lies inside the frame
    logic            result;  // word produces an output
    logic            eof;     // output is the last of the frame
  } tag_t;

  typedef logic [Taps-1:0][CoeffW-1:0] coeff_set_t;

endpackage

[sv/c3zp_ram.sv]
// Generic single-clock RAM, one write and one registered read port.
// No dependencies. Read of an entry written in the same cycle returns old data.
`timescale 1ns / 1ps

module c3zp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/c3zp_seq.sv]
// Configuration registers and raster counters; builds the line-store address,
// the gated pixel and the tag of each accepted word. Depends on c3zp_pkg.
`timescale 1ns / 1ps

module c3zp_seq #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  c3zp_pkg::cfg_idx_t                   cfg_idx_i,
  input  logic [c3zp_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 accept_i,
  input  logic signed [c3zp_pkg::PixW-1:0]     pixel_i,
  input  logic                                 flush_i,
  output logic [$clog2(MAX_WIDTH)-1:0]         addr_o,
  output logic signed [c3zp_pkg::PixW-1:0]     pix_o,
  output c3zp_pkg::tag_t                       tag_o,
  output logic                                 frame_clr_o,
  output c3zp_pkg::coeff_set_t                 coef_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int OW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int ResetW = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
  localparam int ResetH = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [2:0][c3zp_pkg::CfgDataW-1:0] coef_row_q, coef_row_d;
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [OW-1:0] out_row_q, out_row_d;
  logic          pend_q, pend_d;

  logic [c3zp_pkg::GeomW-1:0] geom_val;
  logic [WW-1:0] width_clamp;
  logic [HW-1:0] height_clamp;
  logic          geom_wr;
  logic          beyond, pend_now, in_wrap, out_wrap;
  logic          row0_ok, row2_ok, col0_ok, col2_ok;
  logic [2:0]    row_ok, col_ok;

  always_comb begin
    geom_val = cfg_data_i[c3zp_pkg::GeomW-1:0];
    if (geom_val == '0) begin
      width_clamp  = WW'(1);
      height_clamp = HW'(1);
    end else begin
      width_clamp  = (32'(geom_val) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(geom_val);
      height_clamp = (32'(geom_val) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(geom_val);
    end
  end

  always_comb begin
    beyond   = in_row_q >= RW'(height_q);
    pend_now = pend_q || (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
    in_wrap  = (WW'(in_col_q) + WW'(1)) >= width_q;
    row0_ok  = out_row_q != '0;
    row2_ok  = (HW'(out_row_q) + HW'(1)) < height_q;
    col0_ok  = out_col_q != '0;
    col2_ok  = (WW'(out_col_q) + WW'(1)) < width_q;
    out_wrap = !col2_ok;
    row_ok   = {row2_ok, 1'b1, row0_ok};
    col_ok   = {col2_ok, 1'b1, col0_ok};
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        tag_o.mask[r*3+k] = row_ok[r] && col_ok[k];
      end
    end
    tag_o.result = pend_now;
    tag_o.eof    = pend_now && !row2_ok && !col2_ok;
    addr_o       = in_col_q;
    pix_o        = (flush_i || beyond) ? '0 : pixel_i;
  end

  assign geom_wr     = cfg_we_i &&
                       (cfg_idx_i == c3zp_pkg::CfgImageWidth ||
                        cfg_idx_i == c3zp_pkg::CfgImageHeight);
  assign frame_clr_o = geom_wr;

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    coef_row_d = coef_row_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        c3zp_pkg::CfgImageWidth:  width_d       = width_clamp;
        c3zp_pkg::CfgImageHeight: height_d      = height_clamp;
        c3zp_pkg::CfgCoeffTop:    coef_row_d[0] = cfg_data_i;
        c3zp_pkg::CfgCoeffMid:    coef_row_d[1] = cfg_data_i;
        c3zp_pkg::CfgCoeffBot:    coef_row_d[2] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    if (geom_wr || (accept_i && tag_o.eof)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pend_d    = 1'b0;
    end else if (accept_i) begin
      pend_d = pend_now;
      if (in_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (pend_now) begin
        if (out_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + OW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WW'(ResetW);
      height_q   <= HW'(ResetH);
      coef_row_q <= {3{c3zp_pkg::CoeffRowReset}};
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      pend_q     <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      coef_row_q <= coef_row_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      pend_q     <= pend_d;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        coef_o[r*3+k] = coef_row_q[r][k*c3zp_pkg::CoeffW +: c3zp_pkg::CoeffW];
      end
    end
  end

endmodule

[sv/c3zp_mac.sv]
// 3x3 window, tap masking, nine multipliers and a registered adder tree
// ending in the output register. Depends on c3zp_pkg.
`timescale 1ns / 1ps

module c3zp_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 s1_valid_i,
  input  c3zp_pkg::tag_t                       s1_tag_i,
  input  logic signed [c3zp_pkg::PixW-1:0]     top_i,
  input  logic signed [c3zp_pkg::PixW-1:0]     mid_i,
  input  logic signed [c3zp_pkg::PixW-1:0]     pix_i,
  input  c3zp_pkg::coeff_set_t                 coef_i,
  input  logic                                 frame_clr_i,
  output logic                                 out_valid_o,
  output logic signed [c3zp_pkg::SumW-1:0]     filtered_o,
  output logic                                 eof_o
);

  localparam int Taps = c3zp_pkg::Taps;

  logic signed [c3zp_pkg::PixW-1:0]  win_q [Taps];
  logic signed [c3zp_pkg::PixW-1:0]  win_d [Taps];
  logic signed [c3zp_pkg::PixW-1:0]  tap_q [Taps];
  logic signed [c3zp_pkg::ProdW-1:0] prod_q [Taps];
  logic signed [c3zp_pkg::GrpW-1:0]  grp_q [3];
  logic signed [c3zp_pkg::SumW-1:0]  sum_q;
  logic v2_q, v3_q, v4_q, out_valid_q;
  logic e2_q, e3_q, e4_q, out_eof_q;

  // shift left by one column, new column enters on the right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = top_i;
    win_d[5] = mid_i;
    win_d[8] = pix_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Taps; i++) begin
        win_q[i] <= '0;
      end
    end else if (frame_clr_i || (adv_i && s1_valid_i && s1_tag_i.eof)) begin
      for (int i = 0; i < Taps; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv_i && s1_valid_i) begin
      for (int i = 0; i < Taps; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      v2_q        <= s1_valid_i && s1_tag_i.result;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < Taps; i++) begin
        tap_q[i]  <= s1_tag_i.mask[i] ? win_d[i] : '0;
        prod_q[i] <= tap_q[i] * $signed(coef_i[i]);
      end
      for (int g = 0; g < 3; g++) begin
        grp_q[g] <= c3zp_pkg::GrpW'(prod_q[g*3]) + c3zp_pkg::GrpW'(prod_q[g*3+1]) +
                    c3zp_pkg::GrpW'(prod_q[g*3+2]);
      end
      sum_q     <= c3zp_pkg::SumW'(grp_q[0]) + c3zp_pkg::SumW'(grp_q[1]) +
                   c3zp_pkg::SumW'(grp_q[2]);
      e2_q      <= s1_tag_i.eof;
      e3_q      <= e2_q;
      e4_q      <= e3_q;
      out_eof_q <= e4_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = sum_q;
  assign eof_o       = out_eof_q;

endmodule

[sv/conv2d_3x3_zero_pad.sv]
// Top level of the 3x3 zero-padded convolution: line stores, store forwarding
// and stall control. Depends on c3zp_pkg, c3zp_ram, c3zp_seq, c3zp_mac.
`timescale 1ns / 1ps

// Takes one pixel word per clock in row-major order and returns one 36-bit
// Q.14 weighted sum per pixel, with neighbors outside the frame taken as zero.
// A pixel's result comes out with the word that arrives image_width+1 words
// after it, then passes the line-store read, window tap, multiply and two
// adder-level registers; after the last pixel send image_width+1 flush words.
// Sustained rate is one word per clock while the output is not stalled, set
// by the single read and write per cycle on each of the two MAX_WIDTH-deep
// line stores. The whole pipeline holds while a result is stalled at the
// output, so in_stall_o follows out_stall_i combinationally. No clearing
// pass: entries left from an earlier frame only land in masked taps.
module conv2d_3x3_zero_pad #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [c3zp_pkg::PixW-1:0]     pixel_i,
  input  logic                                 flush_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [c3zp_pkg::SumW-1:0]     filtered_o,
  output logic                                 end_of_frame_o,
  input  logic                                 cfg_we_i,
  input  c3zp_pkg::cfg_idx_t                   cfg_idx_i,
  input  logic [c3zp_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic adv, accept, wr_en;
  logic [CW-1:0] addr0;
  logic signed [c3zp_pkg::PixW-1:0] pix0;
  c3zp_pkg::tag_t tag0;
  logic frame_clr;
  c3zp_pkg::coeff_set_t coef;

  logic s1_valid_q;
  c3zp_pkg::tag_t s1_tag_q;
  logic signed [c3zp_pkg::PixW-1:0] s1_pix_q;
  logic [CW-1:0] s1_addr_q;
  logic s1_fwd_q;
  logic signed [c3zp_pkg::PixW-1:0] fwd_top_q, fwd_mid_q;
  logic [c3zp_pkg::PixW-1:0] upper_rd, lower_rd;
  logic signed [c3zp_pkg::PixW-1:0] top_s1, mid_s1;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign wr_en      = s1_valid_q && adv;

  c3zp_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pixel_i     (pixel_i),
    .flush_i     (flush_i),
    .addr_o      (addr0),
    .pix_o       (pix0),
    .tag_o       (tag0),
    .frame_clr_o (frame_clr),
    .coef_o      (coef)
  );

  // upper store takes the row from the lower store, lower takes the new pixel
  c3zp_ram #(
    .WIDTH (c3zp_pkg::PixW),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_s1),
    .re_i    (accept),
    .raddr_i (addr0),
    .rdata_o (upper_rd)
  );

  c3zp_ram #(
    .WIDTH (c3zp_pkg::PixW),
    .DEPTH (MAX_WIDTH)
  ) u_lower (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (addr0),
    .rdata_o (lower_rd)
  );

  // a read issued while the same column is written returns stale data
  assign top_s1 = s1_fwd_q ? fwd_top_q : $signed(upper_rd);
  assign mid_s1 = s1_fwd_q ? fwd_mid_q : $signed(lower_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tag_q  <= tag0;
      s1_pix_q  <= pix0;
      s1_addr_q <= addr0;
      s1_fwd_q  <= wr_en && (s1_addr_q == addr0);
      fwd_top_q <= mid_s1;
      fwd_mid_q <= s1_pix_q;
    end
  end

  c3zp_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s1_valid_i  (s1_valid_q),
    .s1_tag_i    (s1_tag_q),
    .top_i       (top_s1),
    .mid_i       (mid_s1),
    .pix_i       (s1_pix_q),
    .coef_i      (coef),
    .frame_clr_i (frame_clr),
    .out_valid_o (out_valid_o),
    .filtered_o  (filtered_o),
    .eof_o       (end_of_frame_o)
  );

endmodule

[verif/tb_conv2d_3x3_zero_pad.sv]
// Self-checking testbench for conv2d_3x3_zero_pad: directed and random frames,
// checked word by word against an in-bench model of the convolution.
// Depends on c3zp_pkg and the conv2d_3x3_zero_pad RTL.
`timescale 1ns / 1ps

module tb_conv2d_3x3_zero_pad;
  import c3zp_pkg::*;

  localparam int MaxWidth    = 1024;
  localparam int MaxHeight   = 1024;
  localparam int DrainCycles = 16;
  localparam int LongHold    = 300;
  localparam int StallLimit  = 3000;
  localparam int RandomWords = 340;

  typedef struct {
    logic signed [PixW-1:0] pixel;
    logic                   flush;
  } pixel_word_t;

  typedef struct {
    logic [SumW-1:0] acc;
    logic            eof;
  } conv_result_t;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [PixW-1:0] pixel_i = '0;
  logic                   flush_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [SumW-1:0] filtered_o;
  logic                   end_of_frame_o;
  logic                   cfg_we_i = 1'b0;
  cfg_idx_t               cfg_idx_i = CfgImageWidth;
  logic [CfgDataW-1:0]    cfg_data_i = '0;

  conv2d_3x3_zero_pad dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .flush_i        (flush_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_o     (filtered_o),
    .end_of_frame_o (end_of_frame_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // model state
  logic [GeomW-1:0]       width_reg;
  logic [GeomW-1:0]       height_reg;
  logic [CfgDataW-1:0]    coef_rows [3];
  logic signed [PixW-1:0] upper_line [MaxWidth];
  logic signed [PixW-1:0] lower_line [MaxWidth];
  logic signed [PixW-1:0] win [3][3];
  int unsigned            in_col, in_row, out_col, out_row;
  bit                     pending;

  pixel_word_t  pixel_queue [$];
  conv_result_t expected_sums [$];
  int           words_queued = 0;
  int           words_taken = 0;
  int           errors = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  bit           long_hold_trig = 1'b0;
  bit           long_hold_seen = 1'b0;
  int           hold_left = 0;
  int           idle_cycles = 0;
  pixel_word_t  next_word;

  function automatic int unsigned eff_dim(logic [GeomW-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic restart_frame();
    win = '{default: '0};
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    pending = 1'b0;
  endtask

  task automatic reset_model();
    width_reg = GeomW'(MaxWidth);
    height_reg = GeomW'(MaxHeight);
    for (int r = 0; r < 3; r++) coef_rows[r] = CoeffRowReset;
    for (int i = 0; i < MaxWidth; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    restart_frame();
  endtask

  task automatic apply_reg(cfg_idx_t idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgImageWidth: begin
        width_reg = data[GeomW-1:0];
        restart_frame();
      end
      CfgImageHeight: begin
        height_reg = data[GeomW-1:0];
        restart_frame();
      end
      CfgCoeffTop: coef_rows[0] = data;
      CfgCoeffMid: coef_rows[1] = data;
      CfgCoeffBot: coef_rows[2] = data;
      default: ;
    endcase
  endtask

  // shift one word through the line stores and window; queue the sum it yields
  task automatic convolve_word(logic signed [PixW-1:0] px, logic fl);
    int unsigned            w, h;
    logic signed [PixW-1:0] v, top_px, mid_px;
    longint                 acc;
    bit                     eof, skip;
    conv_result_t           res;
    w = eff_dim(width_reg, MaxWidth);
    h = eff_dim(height_reg, MaxHeight);
    v = (fl || in_row >= h) ? '0 : px;
    top_px = upper_line[in_col];
    mid_px = lower_line[in_col];
    upper_line[in_col] = mid_px;
    lower_line[in_col] = v;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top_px;
    win[1][2] = mid_px;
    win[2][2] = v;
    if (in_row >= 2 || (in_row == 1 && in_col >= 1)) pending = 1'b1;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (pending) begin
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          skip = (r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
                 (k == 0 && out_col == 0) || (k == 2 && out_col + 1 >= w);
          if (!skip)
            acc += longint'(win[r][k]) *
                   longint'($signed(coef_rows[r][CoeffW*k +: CoeffW]));
        end
      end
      eof = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.acc = acc[SumW-1:0];
      res.eof = eof;
      expected_sums.push_back(res);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (eof) restart_frame();
    end
  endtask

  // input side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        convolve_word(pixel_i, flush_i);
        words_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pixel_queue.pop_front();
          in_valid_i <= 1'b1;
          pixel_i <= next_word.pixel;
          flush_i <= next_word.flush;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall, with one long hold-off on request
  always @(posedge clk_i) begin
    if (long_hold_trig && !long_hold_seen) begin
      long_hold_seen <= 1'b1;
      hold_left <= LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result check
  always @(posedge clk_i) begin
    conv_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual filtered=%h eof=%b",
                 $realtime, filtered_o, end_of_frame_o);
      end else begin
        exp_res = expected_sums.pop_front();
        if (filtered_o !== exp_res.acc) begin
          errors++;
          $display("%0t: filtered: expected %h, actual %h",
                   $realtime, exp_res.acc, filtered_o);
        end
        if (end_of_frame_o !== exp_res.eof) begin
          errors++;
          $display("%0t: end_of_frame: expected %b, actual %b",
                   $realtime, exp_res.eof, end_of_frame_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("conv2d_3x3_zero_pad: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic push_word(logic signed [PixW-1:0] px, logic fl);
    pixel_word_t wd;
    wd.pixel = px;
    wd.flush = fl;
    pixel_queue.push_back(wd);
    words_queued++;
  endtask

  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return '1;
      default: return PixW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_coef_row();
    case ($urandom_range(7))
      0: return {3{16'h7FFF}};
      1: return {3{16'h8000}};
      2: return '0;
      3: return CoeffRowReset;
      default: return CfgDataW'({$urandom, $urandom});
    endcase
  endfunction

  // full frame plus drain; the odd in-frame flush and drain pixel included
  task automatic queue_frame();
    int unsigned w, h;
    w = eff_dim(width_reg, MaxWidth);
    h = eff_dim(height_reg, MaxHeight);
    for (int i = 0; i < w * h; i++) push_word(rand_pixel(), $urandom_range(15) == 0);
    for (int i = 0; i <= w; i++) push_word(rand_pixel(), $urandom_range(3) != 0);
  endtask

  task automatic settle();
    while (words_taken != words_queued || expected_sums.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IdleSender: begin
        send_idle_pct = 87;
        stall_pct = 0;
      end
      IdleReceiver: begin
        send_idle_pct = 0;
        stall_pct = 87;
      end
      IdleBoth: begin
        send_idle_pct = 7;
        stall_pct = 7;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    int          start_words, phase, frames, part;
    int unsigned w, h;
    reset_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one short row at reset coefficients; zero height acts as one
    write_reg(CfgImageWidth, CfgDataW'(5));
    write_reg(CfgImageHeight, '0);
    queue_frame();
    settle();

    // 3x3 frame at coefficient extremes
    write_reg(CfgImageWidth, CfgDataW'(3));
    write_reg(CfgImageHeight, CfgDataW'(3));
    write_reg(CfgCoeffTop, {16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(CfgCoeffMid, {16'h8000, 16'h7FFF, 16'h8000});
    write_reg(CfgCoeffBot, {16'h7FFF, 16'h8000, 16'h7FFF});
    for (int i = 0; i < 9; i++) push_word((i % 2) ? 16'sh7FFF : 16'sh8000, i == 4);
    push_word(16'sh8000, 1'b1);
    push_word(16'sh7FFF, 1'b0);
    push_word(16'sh7FFF, 1'b1);
    push_word('0, 1'b1);
    settle();
    for (int i = int'(CfgCoeffBot) + 1; i < (1 << CfgIdxW); i++)
      write_reg(cfg_idx_t'(i), CfgDataW'({$urandom, $urandom}));

    // zero width acts as one
    write_reg(CfgImageWidth, '0);
    write_reg(CfgImageHeight, CfgDataW'(4));
    queue_frame();
    settle();

    // frame cut short by a geometry write
    write_reg(CfgImageWidth, CfgDataW'(6));
    write_reg(CfgImageHeight, CfgDataW'(2));
    for (int i = 0; i < 10; i++) push_word(rand_pixel(), 1'b0);
    settle();
    write_reg(CfgImageWidth, CfgDataW'(2));
    write_reg(CfgImageHeight, CfgDataW'(3));
    queue_frame();
    settle();

    // coefficient change in the middle of a frame
    write_reg(CfgImageWidth, CfgDataW'(4));
    write_reg(CfgImageHeight, CfgDataW'(3));
    for (int i = 0; i < 8; i++) push_word(rand_pixel(), 1'b0);
    settle();
    write_reg(CfgCoeffTop, rand_coef_row());
    for (int i = 0; i < 4; i++) push_word(rand_pixel(), 1'b0);
    for (int i = 0; i < 5; i++) push_word(rand_pixel(), 1'b1);
    settle();

    start_words = words_queued;
    phase = 0;
    while (words_queued - start_words < RandomWords) begin
      set_idling(idle_mode_t'(phase % 4));
      write_reg(CfgImageWidth, ($urandom_range(9) == 0) ? CfgDataW'($urandom_range(40, 10))
                                                          : CfgDataW'($urandom_range(9)));
      write_reg(CfgImageHeight, CfgDataW'($urandom_range(5)));
      write_reg(CfgCoeffTop, rand_coef_row());
      write_reg(CfgCoeffMid, rand_coef_row());
      write_reg(CfgCoeffBot, rand_coef_row());
      if ($urandom_range(3) == 0)
        write_reg(cfg_idx_t'($urandom_range((1 << CfgIdxW) - 1, int'(CfgCoeffBot) + 1)),
                  CfgDataW'({$urandom, $urandom}));
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(4) == 0) begin
          // broken frame, then a restart through the width register
          w = eff_dim(width_reg, MaxWidth);
          h = eff_dim(height_reg, MaxHeight);
          part = $urandom_range(w * h + w, 1);
          for (int i = 0; i < part; i++) push_word(rand_pixel(), $urandom_range(7) == 0);
          settle();
          write_reg(CfgImageWidth, CfgDataW'($urandom_range(9)));
        end else begin
          queue_frame();
          long_hold_trig = 1'b1;
        end
      end
      settle();
      phase++;
    end

    set_idling(IdleNone);
    settle();
    if (errors == 0) begin
      $display("conv2d_3x3_zero_pad: match");
    end else begin
      $display("conv2d_3x3_zero_pad: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
sv/c3zp_pkg.sv
sv/c3zp_ram.sv
sv/c3zp_seq.sv
sv/c3zp_mac.sv
sv/conv2d_3x3_zero_pad.sv
verif/tb_conv2d_3x3_zero_pad.sv
